// ===== hw/rtl/bafr_pkg.sv =====
// Shared types and constants for the RGB box averaging filter.
// Used by box_average_filter_rgb and its testbench; depends on nothing else.
`default_nettype none
package bafr_pkg;
	localparam int PIX_W   = 8;
	localparam int RGB_W   = 3 * PIX_W;
	localparam int SUM_W   = 14;   // 49 * 255 fits
	localparam int NUM_W   = 15;   // 2*sum + k*k fits
	localparam int DEN_W   = 7;    // 2*k*k up to 98
	localparam int KSIDE_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

	typedef logic [PIX_W-1:0] chan_t;
	typedef logic [RGB_W-1:0] rgb_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [NUM_W-1:0] num_t;
endpackage
`default_nettype wire

// ===== hw/rtl/box_average_filter_rgb.sv =====
// RGB box averaging filter: line store memory, window sum sequencer, divider.
// Depends on bafr_pkg.
//
// Usage: configure image_width, image_height and window_size through the
// cfg channel (index 0, 1, 2) while idle; any such write restarts the frame.
// A pending configuration write holds off the input channel for that cycle.
// Stream pixels in raster order on the input channel with req_type 0, then
// send req_type 1 items to flush the tail; the last result carries frame_end.
// One item is worked at a time. An item without a result returns to idle; a
// border result goes straight to the hand-off; an interior result passes
// through the accept, k*k line store reads through the single read port, one
// drain step, a load step and 15 steps of the restoring divider, then the
// hand-off. Results go to an output register; the next item is accepted
// while it waits, and a new result stalls only while that register is full.
// After reset the size is 1024 x 1024 with a 3 x 3 window and positions are
// zero; the line store is not cleared, since each result reads only pixels
// written earlier in the same frame.
`default_nettype none
module box_average_filter_rgb #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output      logic cfg_ready,
	input  wire logic [bafr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bafr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output      logic in_ready,
	input  wire logic req_type,
	input  wire logic [bafr_pkg::PIX_W-1:0] pixel_blue,
	input  wire logic [bafr_pkg::PIX_W-1:0] pixel_green,
	input  wire logic [bafr_pkg::PIX_W-1:0] pixel_red,
	output      logic out_valid,
	input  wire logic out_ready,
	output      logic [bafr_pkg::PIX_W-1:0] out_blue,
	output      logic [bafr_pkg::PIX_W-1:0] out_green,
	output      logic [bafr_pkg::PIX_W-1:0] out_red,
	output      logic frame_end
);
	import bafr_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW   = $clog2(MAX_HEIGHT + MAX_WINDOW + 2);
	localparam int SW   = $clog2(MAX_WINDOW);
	localparam int PW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_WINDOW + 1) + 1);
	localparam int OW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int DW   = $clog2(NUM_W + 1);
	localparam int KMAX = (MAX_WINDOW - 1) | 1;
	localparam int MEM_DEPTH = MAX_WINDOW * (1 << CW);

	typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_DRAIN, ST_LOAD, ST_DIV, ST_DONE} state_t;

	state_t state_q;
	logic [CFG_DATA_W-1:0] image_width_q, image_height_q;
	logic [KSIDE_W-1:0] window_size_q;

	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [SW-1:0] in_slot_q;
	logic [PW-1:0] in_pos_q;
	logic [OW-1:0] out_idx_q;
	logic [WW-1:0] out_c_q;
	logic [HW-1:0] out_r_q;
	logic [SW-1:0] out_slot_q;

	logic [KSIDE_W-1:0] dx_q, dy_q;
	logic [SW-1:0] rd_slot_q;
	logic [CW-1:0] rd_col_q, col_start_q;
	logic rd_v_s1;
	rgb_t rd_data_s1;
	sum_t sum_q [3];
	num_t num_q [3];
	logic [DEN_W-1:0] rem_q [3];
	logic [DEN_W-1:0] den_q;
	logic [DW-1:0] step_q;
	logic last_q, zero_q;

	logic out_valid_q, frame_end_q;
	chan_t out_ch_q [3];

	rgb_t mem [MEM_DEPTH];

	// effective geometry
	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic [KSIDE_W-1:0] k_c, n_c;
	logic [5:0] k2_c;
	logic [PW-1:0] lag_c;
	logic [OW-1:0] total_c;

	always_comb begin
		if (image_width_q == '0) w_c = WW'(1);
		else if (int'(image_width_q) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
		else w_c = WW'(image_width_q);
		if (image_height_q == '0) h_c = HW'(1);
		else if (int'(image_height_q) > MAX_HEIGHT) h_c = HW'(MAX_HEIGHT);
		else h_c = HW'(image_height_q);
		if (!window_size_q[0]) k_c = KSIDE_W'(1);
		else if (int'(window_size_q) > KMAX) k_c = KSIDE_W'(KMAX);
		else k_c = window_size_q;
		n_c     = k_c >> 1;
		k2_c    = 6'(k_c) * 6'(k_c);
		lag_c   = PW'(n_c) * PW'(w_c) + PW'(n_c);
		total_c = OW'(w_c) * OW'(h_c);
	end

	logic inputting_c, is_pix_c, interior_c, last_c;
	logic [SW-1:0] slot_start_c;
	always_comb begin
		inputting_c = (RW + 1)'(in_row_q) < (RW + 1)'(h_c);
		is_pix_c    = inputting_c && !req_type;
		interior_c  = (out_r_q >= HW'(n_c)) && ((HW + 1)'(out_r_q) + (HW + 1)'(n_c) <
			(HW + 1)'(h_c)) && (out_c_q >= WW'(n_c)) &&
			((WW + 1)'(out_c_q) + (WW + 1)'(n_c) < (WW + 1)'(w_c));
		last_c = (OW + 1)'(out_idx_q) + (OW + 1)'(1) >= (OW + 1)'(total_c);
		if ((SW + 1)'(out_slot_q) >= (SW + 1)'(n_c))
			slot_start_c = SW'((SW + 1)'(out_slot_q) - (SW + 1)'(n_c));
		else
			slot_start_c = SW'((SW + 2)'(out_slot_q) + (SW + 2)'(MAX_WINDOW) - (SW + 2)'(n_c));
	end

	// divider step, one quotient bit per cycle for each channel
	num_t num_n [3];
	logic [DEN_W-1:0] rem_n [3];
	always_comb begin
		logic [DEN_W:0] trial;
		for (int i = 0; i < 3; i++) begin
			trial = {rem_q[i], num_q[i][NUM_W-1]};
			if (trial >= {1'b0, den_q}) begin
				rem_n[i] = DEN_W'(trial - {1'b0, den_q});
				num_n[i] = {num_q[i][NUM_W-2:0], 1'b1};
			end else begin
				rem_n[i] = trial[DEN_W-1:0];
				num_n[i] = {num_q[i][NUM_W-2:0], 1'b0};
			end
		end
	end

	logic accept_in, accept_cfg, mem_we;
	assign cfg_ready  = (state_q == ST_IDLE);
	assign in_ready   = (state_q == ST_IDLE) && !cfg_valid;
	assign accept_in  = in_valid && in_ready;
	assign accept_cfg = cfg_valid && cfg_ready;
	assign mem_we     = accept_in && is_pix_c;

	always_ff @(posedge clk) begin
		if (mem_we) mem[{in_slot_q, in_col_q}] <= {pixel_red, pixel_green, pixel_blue};
		rd_data_s1 <= mem[{rd_slot_q, rd_col_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			image_width_q <= CFG_DATA_W'(1024);
			image_height_q <= CFG_DATA_W'(1024);
			window_size_q <= KSIDE_W'(3);
			in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0; in_pos_q <= '0;
			out_idx_q <= '0; out_c_q <= '0; out_r_q <= '0; out_slot_q <= '0;
			dx_q <= '0; dy_q <= '0; rd_slot_q <= '0; rd_col_q <= '0; col_start_q <= '0;
			rd_v_s1 <= 1'b0;
			den_q <= '0; step_q <= '0; last_q <= 1'b0; zero_q <= 1'b0;
			out_valid_q <= 1'b0; frame_end_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0; num_q[i] <= '0; rem_q[i] <= '0; out_ch_q[i] <= '0;
			end
		end else begin
			// drop the item once taken, unless a new result replaces it
			if (out_valid_q && out_ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			rd_v_s1 <= (state_q == ST_ACC);
			if (rd_v_s1) begin
				for (int i = 0; i < 3; i++)
					sum_q[i] <= sum_q[i] + SUM_W'(rd_data_s1[i*PIX_W +: PIX_W]);
			end

			if (accept_cfg && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
				REG_WINDOW_SIZE})) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  image_width_q <= cfg_data;
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
					REG_WINDOW_SIZE:  window_size_q <= cfg_data[KSIDE_W-1:0];
					default: ;
				endcase
				in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0; in_pos_q <= '0;
				out_idx_q <= '0; out_c_q <= '0; out_r_q <= '0; out_slot_q <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// padding while pixels are still expected is dropped
					if (accept_in && (is_pix_c || !inputting_c)) begin
						in_pos_q <= in_pos_q + PW'(1);
						if ((WW + 1)'(in_col_q) + (WW + 1)'(1) >= (WW + 1)'(w_c)) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + RW'(1);
							in_slot_q <= (int'(in_slot_q) == MAX_WINDOW - 1) ? '0 :
								in_slot_q + SW'(1);
						end else begin
							in_col_q <= in_col_q + CW'(1);
						end
						if (in_pos_q >= lag_c) begin
							last_q <= last_c;
							zero_q <= !interior_c;
							dx_q <= '0;
							dy_q <= '0;
							rd_slot_q <= slot_start_c;
							rd_col_q <= CW'(out_c_q - WW'(n_c));
							col_start_q <= CW'(out_c_q - WW'(n_c));
							for (int i = 0; i < 3; i++) sum_q[i] <= '0;
							state_q <= interior_c ? ST_ACC : ST_DONE;
						end
					end
				end
				ST_ACC: begin
					if (dx_q == k_c - KSIDE_W'(1)) begin
						dx_q <= '0;
						rd_col_q <= col_start_q;
						rd_slot_q <= (int'(rd_slot_q) == MAX_WINDOW - 1) ? '0 :
							rd_slot_q + SW'(1);
						dy_q <= dy_q + KSIDE_W'(1);
						if (dy_q == k_c - KSIDE_W'(1)) state_q <= ST_DRAIN;
					end else begin
						dx_q <= dx_q + KSIDE_W'(1);
						rd_col_q <= rd_col_q + CW'(1);
					end
				end
				ST_DRAIN: state_q <= ST_LOAD;
				ST_LOAD: begin
					den_q <= DEN_W'({k2_c, 1'b0});
					step_q <= '0;
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= NUM_W'({sum_q[i], 1'b0}) + NUM_W'(k2_c);
						rem_q[i] <= '0;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= num_n[i];
						rem_q[i] <= rem_n[i];
					end
					step_q <= step_q + DW'(1);
					if (step_q == DW'(NUM_W - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						frame_end_q <= last_q;
						for (int i = 0; i < 3; i++)
							out_ch_q[i] <= zero_q ? '0 : num_q[i][PIX_W-1:0];
						if (last_q) begin
							in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0; in_pos_q <= '0;
							out_idx_q <= '0; out_c_q <= '0; out_r_q <= '0; out_slot_q <= '0;
						end else begin
							out_idx_q <= out_idx_q + OW'(1);
							if ((WW + 1)'(out_c_q) + (WW + 1)'(1) >= (WW + 1)'(w_c)) begin
								out_c_q <= '0;
								out_r_q <= out_r_q + HW'(1);
								out_slot_q <= (int'(out_slot_q) == MAX_WINDOW - 1) ? '0 :
									out_slot_q + SW'(1);
							end else begin
								out_c_q <= out_c_q + WW'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign frame_end = frame_end_q;
	assign out_blue  = out_ch_q[0];
	assign out_green = out_ch_q[1];
	assign out_red   = out_ch_q[2];
endmodule
`default_nettype wire

// ===== tb/sv/box_average_filter_rgb_test.sv =====
// Testbench for box_average_filter_rgb: drives pixel and padding items, keeps
// its own windowed-mean predictor of the line store, and checks each result.
// Depends on bafr_pkg and box_average_filter_rgb.
`default_nettype none
module box_average_filter_rgb_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bafr_pkg::*;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int MAXK = 7;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int ITEM_TARGET = 1100;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
		logic  last;
	} mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	chan_t pixel_blue = '0, pixel_green = '0, pixel_red = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	chan_t out_blue, out_green, out_red;
	logic frame_end;

	box_average_filter_rgb i_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	rgb_t lines[MAXK][MAXW];
	int unsigned reg_width = 1024, reg_height = 1024, reg_window = 3;
	int unsigned col_pos, row_pos, next_out;
	mean_t pending_means[$];
	int mismatches, results_seen, items_sent;
	longint cycles;
	bit long_hold, stall_on;

	function automatic int unsigned frame_w();
		if (reg_width == 0) return 1;
		return (reg_width > MAXW) ? MAXW : reg_width;
	endfunction

	function automatic int unsigned frame_h();
		if (reg_height == 0) return 1;
		return (reg_height > MAXH) ? MAXH : reg_height;
	endfunction

	function automatic int unsigned side_k();
		if (reg_window[0] == 1'b0) return 1;
		return (reg_window > MAXK) ? MAXK : reg_window;
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		next_out = 0;
	endfunction

	function automatic void predict_item(logic rq, chan_t b, chan_t g, chan_t r);
		int unsigned w, h, k, n, pos, o, orow, ocol, k2;
		int unsigned sb, sg, sr;
		rgb_t p;
		mean_t m;
		w = frame_w();
		h = frame_h();
		k = side_k();
		n = k / 2;
		if (row_pos < h && rq) return;
		if (row_pos < h) lines[row_pos % MAXK][col_pos % MAXW] = {r, g, b};
		pos = row_pos * w + col_pos;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (pos < n * w + n) return;
		o = next_out;
		orow = o / w;
		ocol = o % w;
		m = '0;
		if (orow >= n && orow + n < h && ocol >= n && ocol + n < w) begin
			sb = 0; sg = 0; sr = 0;
			k2 = k * k;
			for (int dy = 0; dy < k; dy++)
				for (int dx = 0; dx < k; dx++) begin
					p = lines[(orow - n + dy) % MAXK][(ocol - n + dx) % MAXW];
					sb += p[7:0];
					sg += p[15:8];
					sr += p[23:16];
				end
			m.blue = chan_t'((2 * sb + k2) / (2 * k2));
			m.green = chan_t'((2 * sg + k2) / (2 * k2));
			m.red = chan_t'((2 * sr + k2) / (2 * k2));
		end
		m.last = (o + 1 >= w * h);
		pending_means.push_back(m);
		if (m.last) restart_frame();
		else next_out = o + 1;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		while (pending_means.size() != 0) @(posedge clk);
		// let the output register settle before touching the sizes
		repeat (70) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: reg_width = value & 11'h7FF;
			REG_IMAGE_HEIGHT: reg_height = value & 11'h7FF;
			REG_WINDOW_SIZE: reg_window = value & 7;
			default: return;
		endcase
		restart_frame();
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned k);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_WINDOW_SIZE, k);
	endtask

	// offer one item and hold it until accepted
	task automatic send_item(logic rq, chan_t b, chan_t g, chan_t r);
		in_valid <= 1'b1;
		req_type <= rq;
		pixel_blue <= b;
		pixel_green <= g;
		pixel_red <= r;
		do @(posedge clk); while (!in_ready);
		predict_item(rq, b, g, r);
		items_sent++;
	endtask

	task automatic idle_gap(bit bursty);
		if (bursty && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// stream a whole frame, padding until frame_end is predicted
	task automatic run_frame(int mode, bit bursty, bit with_noise);
		int unsigned total;
		chan_t b, g, r;
		total = frame_w() * frame_h();
		for (int i = 0; i < total; i++) begin
			case (mode)
				0: begin
					b = chan_t'($urandom); g = chan_t'($urandom); r = chan_t'($urandom);
				end
				1: begin b = 8'hFF; g = 8'hFF; r = 8'hFF; end
				2: begin b = 8'h00; g = 8'h00; r = 8'h00; end
				default: begin b = i[0] ? 8'hFF : 8'h00; g = ~b; r = i[7:0]; end
			endcase
			if (with_noise && $urandom_range(0, 15) == 0)
				send_item(1'b1, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
			send_item(1'b0, b, g, r);
			idle_gap(bursty);
		end
		while (row_pos != 0 || col_pos != 0) begin
			// a pixel during the flush acts as padding
			if (with_noise && $urandom_range(0, 3) == 0)
				send_item(1'b0, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
			else
				send_item(1'b1, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
			idle_gap(bursty);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		set_frame(5, 4, 3);
		run_frame(1, 0, 1);
		set_frame(4, 3, 7);    // frame smaller than the window
		run_frame(0, 0, 0);
		set_frame(3, 2, 4);    // even side: passthrough
		run_frame(3, 0, 0);
		set_frame(0, 0, 0);    // zero sizes act as one
		run_frame(0, 0, 0);
		write_reg(REG_UNKNOWN, 5);
	endtask

	task automatic test_extremes();
		set_frame(9, 8, 7);
		run_frame(1, 1, 0);
		run_frame(2, 1, 0);
		set_frame(12, 10, 5);
		run_frame(3, 1, 0);
		set_frame(1, 10, 1);   // single column
		run_frame(0, 1, 0);
	endtask

	task automatic test_random();
		int unsigned k;
		while (items_sent < ITEM_TARGET) begin
			k = $urandom_range(0, 7);
			set_frame($urandom_range(1, 12), $urandom_range(1, 10), k);
			run_frame($urandom_range(0, 3), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_backpressure();
		set_frame(8, 6, 3);
		long_hold = 1'b1;
		run_frame(0, 0, 0);
		long_hold = 1'b0;
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (long_hold) out_ready <= 1'b0;
		else if (stall_on) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= 1'b1;
		if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
	end

	// hold-off counter releases the long stall after a while
	always @(posedge clk) begin
		int unsigned hold_count;
		if (long_hold) begin
			hold_count++;
			if (hold_count == 400) long_hold <= 1'b0;
		end else hold_count = 0;
	end

	always @(posedge clk) begin
		mean_t want;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_means.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h %h %b",
					out_blue, out_green, out_red, frame_end);
			end else begin
				want = pending_means.pop_front();
				if (want != {out_blue, out_green, out_red, frame_end}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected b%h g%h r%h e%b got b%h g%h r%h e%b",
							want.blue, want.green, want.red, want.last,
							out_blue, out_green, out_red, frame_end);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("box_average_filter_rgb_test: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extremes();
		test_backpressure();
		test_random();
		while (pending_means.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		mismatches += pending_means.size();
		$display("covered %0d items and %0d results over many frame sizes and windows",
			items_sent, results_seen);
		if (mismatches == 0) $display("box_average_filter_rgb_test: done, clean");
		else $display("box_average_filter_rgb_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== box_average_filter_rgb.f =====
hw/rtl/bafr_pkg.sv
hw/rtl/box_average_filter_rgb.sv
tb/sv/box_average_filter_rgb_test.sv
